// ===== rtl/lpht_pkg.sv =====
// Shared types, constants and key hashing function for the linear probe hash table.
package lpht_pkg;

   // Payload widths fixed by the transaction format
   localparam int FUNC_W        = 2;
   localparam int KEY_W         = 64;
   localparam int VALUE_W       = 32;
   localparam int ENTRY_COUNT_W = 7;
   localparam int MAX_KEY_BYTES = 8;
   // Sum of up to eight bytes stays below 2048
   localparam int SUM_W         = 11;

   // Defaults for the top-level parameters
   localparam int DEF_TABLE_SLOTS = 64;
   localparam int DEF_KEY_BYTES   = 8;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_UNSET = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

   // Slot status codes
   localparam int SLOT_STATUS_W = 2;
   localparam logic [SLOT_STATUS_W-1:0] STATUS_EMPTY    = 2'd0;
   localparam logic [SLOT_STATUS_W-1:0] STATUS_OCCUPIED = 2'd1;
   localparam logic [SLOT_STATUS_W-1:0] STATUS_DELETED  = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SUM_W-1:0] sum;
   } norm_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic load_req;
      logic hash_q;
      logic hash_mod;
      logic issue;
      logic probe;
      logic finish_nop;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic func_bad;
      logic stop;
   } sts_type;

   // Cut the key at its first zero byte and sum the bytes before it
   function automatic norm_type norm_key(input logic [KEY_W-1:0] raw, input int key_bytes);
      norm_type   n;
      logic       live;
      logic [7:0] b;
      n.key = '0;
      n.sum = '0;
      live  = 1'b1;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         b = raw[8*i +: 8];
         if (i >= key_bytes || b == 8'd0) begin
            live = 1'b0;
         end
         if (live) begin
            n.key[8*i +: 8] = b;
            n.sum = n.sum + SUM_W'(b);
         end
      end
      return n;
   endfunction

endpackage

// ===== rtl/lpht_chan_if.sv =====
// Request and response channel interfaces of the linear probe hash table.
interface lpht_req_if import lpht_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [KEY_W-1:0]          key;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      ok;
   logic signed [VALUE_W-1:0] found_value;
   logic [ENTRY_COUNT_W-1:0]  entry_count;

   modport source (output valid, output ok, output found_value, output entry_count,
                   input ready);
   modport sink   (input valid, input ok, input found_value, input entry_count,
                   output ready);
endinterface

// ===== rtl/lpht_ctrl.sv =====
// Controller state machine: sequences clearing, hashing, probing and result hand-off.
module lpht_ctrl import lpht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HASH  = 7'b0000100,
      S_MOD   = 7'b0001000,
      S_ISSUE = 7'b0010000,
      S_PROBE = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash_q = 1'b1;
            state_in   = S_MOD;
         end
         S_MOD: begin
            if (sts.func_bad) begin
               cmd.finish_nop = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.hash_mod = 1'b1;
               state_in     = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            cmd.probe = 1'b1;
            if (sts.stop) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // Hold the response valid until the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The clearing pass runs once after reset only
   a_no_reclear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CLEAR) |=> (state_ff != S_CLEAR))
      else $error("clearing pass re-entered without reset");

   // A finished result leaves as soon as the output register is free
   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("finished result not handed to the output register");

   // A probe step ends only through a stop or continues probing
   a_probe_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && !sts.stop) |=> (state_ff == S_PROBE))
      else $error("probe left without a stop condition");

endmodule

// ===== rtl/lpht_datapath.sv =====
// Datapath: key hashing, slot memories, probe evaluation, entry count and output register.
module lpht_datapath import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output sts_type                   sts,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic [KEY_W-1:0]          req_key,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_ok,
   output logic signed [VALUE_W-1:0] rsp_found_value,
   output logic [ENTRY_COUNT_W-1:0]  rsp_entry_count
);

   localparam int IDX_W     = $clog2(TABLE_SLOTS);
   localparam int N_W       = $clog2(TABLE_SLOTS + 1);
   localparam int CNT_REG_W = (N_W > ENTRY_COUNT_W) ? N_W : ENTRY_COUNT_W;
   localparam int EXT_W     = SUM_W + N_W;
   localparam int PROD_W    = 2 * SUM_W;
   // Reciprocal scaled by 2**SUM_W; the quotient estimate is low by at most one
   localparam int RECIP     = (1 << SUM_W) / TABLE_SLOTS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   // Slot memories
   logic [SLOT_STATUS_W-1:0] status_mem [TABLE_SLOTS];
   logic [KEY_W-1:0]         key_mem    [TABLE_SLOTS];
   logic [VALUE_W-1:0]       value_mem  [TABLE_SLOTS];

   logic [SLOT_STATUS_W-1:0] rd_status_ff;
   logic [KEY_W-1:0]         rd_key_ff;
   logic [VALUE_W-1:0]       rd_value_ff;

   // Transaction and hashing registers
   logic [FUNC_W-1:0]  func_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SUM_W-1:0]   q_ff, q_in;
   logic [IDX_W-1:0]   home_ff, home_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [IDX_W-1:0]   idx_next;
   norm_type           norm;

   // Probe control state
   logic                 have_del_ff, have_del_in;
   logic [IDX_W-1:0]     del_idx_ff, del_idx_in;
   logic [CNT_REG_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]     clr_idx_ff;

   // Pending result and output register
   logic                     res_ok_ff, res_ok_in;
   logic [VALUE_W-1:0]       res_fval_ff, res_fval_in;
   logic [ENTRY_COUNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic                     out_ok_ff;
   logic [VALUE_W-1:0]       out_fval_ff;
   logic [ENTRY_COUNT_W-1:0] out_cnt_ff;

   // Hashing arithmetic
   logic [PROD_W-1:0] q_prod;
   logic [EXT_W-1:0]  qn_prod, rem, rem_fix;

   // Memory write controls
   logic                     st_wr_en;
   logic [IDX_W-1:0]         st_wr_addr;
   logic [SLOT_STATUS_W-1:0] st_wr_data;
   logic                     kv_wr_en;
   logic [IDX_W-1:0]         kv_wr_addr;
   logic [IDX_W-1:0]         ins_addr;

   // Probe decode
   logic probe_empty, probe_deleted, slot_match, probe_last, probe_stop, probe_ok;
   logic [VALUE_W-1:0] probe_fval;

   function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : (i + 1'b1);
   endfunction

   assign norm = norm_key(req_key, KEY_BYTES);

   // Home slot: sum modulo slot count by reciprocal and one correction
   assign q_prod  = PROD_W'(sum_ff) * PROD_W'(RECIP);
   assign q_in    = q_prod[PROD_W-1:SUM_W];
   assign qn_prod = EXT_W'(q_ff) * EXT_W'(TABLE_SLOTS);
   assign rem     = EXT_W'(sum_ff) - qn_prod;
   assign rem_fix = (rem >= EXT_W'(TABLE_SLOTS)) ? (rem - EXT_W'(TABLE_SLOTS)) : rem;
   assign home_in = rem_fix[IDX_W-1:0];

   // Advance the probe address with wrap
   assign idx_next = (idx_ff == LAST_IDX) ? '0 : (idx_ff + 1'b1);

   always_comb begin
      idx_in = idx_ff;
      cur_in = cur_ff;
      if (cmd.hash_mod) begin
         idx_in = home_in;
      end else if (cmd.issue || cmd.probe) begin
         cur_in = idx_ff;
         idx_in = idx_next;
      end
   end

   // Decode the slot read for the current probe position
   assign probe_empty   = (rd_status_ff == STATUS_EMPTY);
   assign probe_deleted = (rd_status_ff == STATUS_DELETED);
   assign slot_match    = (rd_status_ff == STATUS_OCCUPIED) && (rd_key_ff == key_ff);
   assign probe_last    = (idx_ff == home_ff);
   assign probe_stop    = probe_empty || slot_match || probe_last;
   assign ins_addr      = have_del_ff ? del_idx_ff : cur_ff;

   // Act on the probed slot
   always_comb begin
      st_wr_en    = 1'b0;
      st_wr_addr  = clr_idx_ff;
      st_wr_data  = STATUS_EMPTY;
      kv_wr_en    = 1'b0;
      kv_wr_addr  = cur_ff;
      count_in    = count_ff;
      have_del_in = have_del_ff;
      del_idx_in  = del_idx_ff;
      probe_ok    = 1'b0;
      probe_fval  = '0;
      res_ok_in   = res_ok_ff;
      res_fval_in = res_fval_ff;
      res_cnt_in  = res_cnt_ff;
      if (cmd.clear) begin
         st_wr_en = 1'b1;
      end
      if (cmd.issue) begin
         have_del_in = 1'b0;
      end
      if (cmd.probe) begin
         if (probe_empty) begin
            if (func_ff == FUNC_SET) begin
               st_wr_en   = 1'b1;
               st_wr_addr = ins_addr;
               st_wr_data = STATUS_OCCUPIED;
               kv_wr_en   = 1'b1;
               kv_wr_addr = ins_addr;
               count_in   = count_ff + 1'b1;
               probe_ok   = 1'b1;
            end
         end else if (slot_match) begin
            probe_ok = 1'b1;
            if (func_ff == FUNC_SET) begin
               kv_wr_en = 1'b1;
            end else if (func_ff == FUNC_UNSET) begin
               st_wr_en   = 1'b1;
               st_wr_addr = cur_ff;
               st_wr_data = STATUS_DELETED;
               if (count_ff != '0) begin
                  count_in = count_ff - 1'b1;
               end
            end else begin
               probe_fval = rd_value_ff;
            end
         end else if (probe_deleted && func_ff == FUNC_SET && !have_del_ff) begin
            have_del_in = 1'b1;
            del_idx_in  = cur_ff;
         end
         if (probe_stop) begin
            res_ok_in   = probe_ok;
            res_fval_in = probe_fval;
            res_cnt_in  = count_in[ENTRY_COUNT_W-1:0];
         end
      end
      if (cmd.finish_nop) begin
         res_ok_in   = 1'b0;
         res_fval_in = '0;
         res_cnt_in  = count_ff[ENTRY_COUNT_W-1:0];
      end
   end

   // Slot memories: one write port each, registered read at the probe address
   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         status_mem[st_wr_addr] <= st_wr_data;
      end
      if (kv_wr_en) begin
         key_mem[kv_wr_addr]   <= key_ff;
         value_mem[kv_wr_addr] <= value_ff;
      end
      rd_status_ff <= status_mem[idx_ff];
      rd_key_ff    <= key_mem[idx_ff];
      rd_value_ff  <= value_mem[idx_ff];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         clr_idx_ff  <= '0;
         have_del_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         have_del_ff <= have_del_in;
         if (cmd.clear) begin
            clr_idx_ff <= idx_wrap(clr_idx_ff);
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff  <= req_func;
         key_ff   <= norm.key;
         value_ff <= req_value;
         sum_ff   <= norm.sum;
      end
      if (cmd.hash_q) begin
         q_ff <= q_in;
      end
      if (cmd.hash_mod) begin
         home_ff <= home_in;
      end
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      del_idx_ff  <= del_idx_in;
      res_ok_ff   <= res_ok_in;
      res_fval_ff <= res_fval_in;
      res_cnt_ff  <= res_cnt_in;
      if (cmd.load_out) begin
         out_ok_ff   <= res_ok_ff;
         out_fval_ff <= res_fval_ff;
         out_cnt_ff  <= res_cnt_ff;
      end
   end

   assign sts.clear_last = (clr_idx_ff == LAST_IDX);
   assign sts.func_bad   = !(func_ff == FUNC_SET || func_ff == FUNC_UNSET ||
                             func_ff == FUNC_FIND);
   assign sts.stop       = probe_stop;

   assign rsp_ok          = out_ok_ff;
   assign rsp_found_value = out_fval_ff;
   assign rsp_entry_count = out_cnt_ff;

   // The entry count never exceeds the slot count
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_REG_W'(TABLE_SLOTS))
      else $error("entry count above slot count");

   // The entry count changes only on a probe step
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !cmd.probe |=> $stable(count_ff))
      else $error("entry count moved outside a probe");

   // The reduced home slot lies inside the table
   a_home_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.hash_mod) |-> (home_ff <= LAST_IDX))
      else $error("home slot out of range");

endmodule

// ===== rtl/linear_probe_hash_table_top.sv =====
// One transaction at a time: a request is accepted only after the previous result has entered
// the output register. A transaction probes 1 to TABLE_SLOTS slots, one slot per cycle; an
// unused operation code skips the probe and gives a failed result.
// Reset: synchronous; a clearing pass then marks every slot empty, during which no request
// is accepted.
// Top level of the linear probe hash table: controller and datapath.
module linear_probe_hash_table_top import lpht_pkg::*; #(
   parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
   parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
   input logic        clock,
   input logic        reset,
   lpht_req_if.sink   req_chan,
   lpht_rsp_if.source rsp_chan
);

   cmd_type cmd;
   sts_type sts;

   // Sequence each transaction
   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hash, probe and store
   lpht_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .KEY_BYTES   (KEY_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_chan.func),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .rsp_ok          (rsp_chan.ok),
      .rsp_found_value (rsp_chan.found_value),
      .rsp_entry_count (rsp_chan.entry_count)
   );

endmodule
